/* design/sacm_pkg.sv */
// Shared types and constants for the sonar approach and collision monitor.
package sacm_pkg;

   localparam int SENSOR_COUNT          = 7;
   localparam int HISTORY_DEPTH_DEFAULT = 4;
   localparam int IDX_W                 = 3;
   localparam int DIST_W                = 16;
   localparam int QUEUE_DEPTH           = 2;

   localparam logic [DIST_W-1:0]       THRESHOLD_RESET = 16'd300;
   // front sonars 1..3, side and rear sonars 0, 4, 5, 6
   localparam logic [SENSOR_COUNT-1:0] FRONT_MASK      = 7'b0001110;
   localparam logic [SENSOR_COUNT-1:0] SIDE_MASK       = 7'b1110001;

   typedef struct packed {
      logic [IDX_W-1:0]  sensor_index;
      logic [DIST_W-1:0] distance;
   } req_type;

   typedef struct packed {
      logic                    approaching;
      logic                    stop_command;
      logic [SENSOR_COUNT-1:0] risk_mask;
   } rsp_type;

   typedef struct packed {
      logic              write_en;
      logic [IDX_W-1:0]  sensor;
      logic [DIST_W-1:0] distance;
   } cmd_type;

endpackage

/* design/sacm_front.sv */
// Front end: accepts readings and classifies them into commands for the queue.
module sacm_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  sacm_pkg::req_type req_payload,
   output logic             push,
   input  logic             push_ready,
   output sacm_pkg::cmd_type cmd
);
   import sacm_pkg::*;

   assign req_ready = push_ready;
   assign push      = req_valid;

   always_comb begin
      // an out-of-range sensor still yields a result but touches no sonar history
      cmd.write_en = (req_payload.sensor_index < IDX_W'(SENSOR_COUNT));
      cmd.sensor   = req_payload.sensor_index;
      cmd.distance = req_payload.distance;
   end

endmodule

/* design/sacm_queue.sv */
// Small command queue between the front and back ends.
module sacm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sacm_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output sacm_pkg::cmd_type out_data
);
   import sacm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* design/sacm_back.sv */
// Back end: per-sensor history state, approach and collision evaluation, result register.
module sacm_back #(
   parameter int HISTORY_DEPTH = sacm_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  sacm_pkg::cmd_type             cmd,
   input  logic                          csr_write,
   input  logic [sacm_pkg::DIST_W-1:0]   csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sacm_pkg::rsp_type             rsp_payload
);
   import sacm_pkg::*;

   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(HISTORY_DEPTH);
   localparam logic [CNT_W-1:0] RUN_FULL  = CNT_W'(HISTORY_DEPTH - 1);

   // History is kept as newest reading, fill count and length of the
   // strictly falling run ending at the newest reading.
   logic [DIST_W-1:0]       last_ff  [SENSOR_COUNT];
   logic [DIST_W-1:0]       last_in  [SENSOR_COUNT];
   logic [CNT_W-1:0]        fill_ff  [SENSOR_COUNT];
   logic [CNT_W-1:0]        fill_in  [SENSOR_COUNT];
   logic [CNT_W-1:0]        run_ff   [SENSOR_COUNT];
   logic [CNT_W-1:0]        run_in   [SENSOR_COUNT];
   logic [SENSOR_COUNT-1:0] latch_ff, latch_in;
   logic [DIST_W-1:0]       threshold_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff, rsp_in;
   logic                    pop;

   assign cmd_ready   = !rsp_valid_ff || rsp_ready;
   assign pop         = cmd_valid && cmd_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      logic approach;
      logic stop;
      approach = 1'b0;
      stop     = 1'b0;
      latch_in = latch_ff;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
         last_in[s] = last_ff[s];
         fill_in[s] = fill_ff[s];
         run_in[s]  = run_ff[s];
         if (cmd.write_en && (cmd.sensor == IDX_W'(s))) begin
            last_in[s] = cmd.distance;
            if (fill_ff[s] != FILL_FULL) begin
               fill_in[s] = fill_ff[s] + 1'b1;
            end
            if ((fill_ff[s] != '0) && (cmd.distance < last_ff[s])) begin
               if (run_ff[s] != RUN_FULL) begin
                  run_in[s] = run_ff[s] + 1'b1;
               end
            end else begin
               run_in[s] = '0;
            end
         end
      end
      for (int s = 0; s < SENSOR_COUNT; s++) begin
         if (FRONT_MASK[s] && (fill_in[s] == FILL_FULL) && (run_in[s] == RUN_FULL)) begin
            approach = 1'b1;
         end
         if (SIDE_MASK[s] && (fill_in[s] != '0)) begin
            if (last_in[s] < threshold_ff) begin
               if (!latch_ff[s]) begin
                  stop = 1'b1;
               end
               latch_in[s] = 1'b1;
            end else begin
               latch_in[s] = 1'b0;
            end
         end
      end
      rsp_in.approaching  = approach;
      rsp_in.stop_command = stop;
      rsp_in.risk_mask    = latch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SENSOR_COUNT; s++) begin
            fill_ff[s] <= '0;
            run_ff[s]  <= '0;
         end
         latch_ff     <= '0;
         threshold_ff <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            threshold_ff <= csr_wdata;
         end
         if (pop) begin
            for (int s = 0; s < SENSOR_COUNT; s++) begin
               fill_ff[s] <= fill_in[s];
               run_ff[s]  <= run_in[s];
            end
            latch_ff     <= latch_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int s = 0; s < SENSOR_COUNT; s++) begin
            last_ff[s] <= last_in[s];
         end
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* design/sonar_approach_collision_monitor.sv */
// Sonar approach and collision monitor, top level.
//
// req channel: one reading (sensor_index, distance) per transfer.
// rsp channel: one result (approaching, stop_command, risk_mask) per reading,
//   in order. approaching flags a front sonar (1..3) whose last HISTORY_DEPTH
//   readings fall strictly; risk_mask holds the collision latch of sonars
//   0, 4, 5 and 6; stop_command marks a latch newly set by this reading.
// csr channel: write of the risk threshold (tenths of cm), always ready;
//   write only while no reading is in flight.
// A reading passes the queue and then the result register on its way to rsp.
//   Throughput: one reading per cycle while rsp_ready stays high; the back end
//   evaluates all sonars in the single cycle in which it takes a command.
// A two-entry queue decouples the front end from the back end, so req_ready
//   drops only once the result register is held by rsp_ready low and the
//   queue has filled.
// Reset: histories empty, latches clear, threshold 300 (30.0 cm); no result
//   pending. A sensor index of seven changes no history but still gets a result.
module sonar_approach_collision_monitor #(
   parameter int HISTORY_DEPTH = sacm_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sacm_pkg::req_type           req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sacm_pkg::rsp_type           rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sacm_pkg::DIST_W-1:0] csr_wdata
);
   import sacm_pkg::*;

   logic    push, push_ready;
   cmd_type push_cmd;
   logic    q_valid, q_ready;
   cmd_type q_cmd;

   assign csr_ready = 1'b1;

   sacm_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push        (push),
      .push_ready  (push_ready),
      .cmd         (push_cmd)
   );

   sacm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_ready  (push_ready),
      .in_data   (push_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_cmd)
   );

   sacm_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (q_valid),
      .cmd_ready   (q_ready),
      .cmd         (q_cmd),
      .csr_write   (csr_valid && csr_ready),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // front sonars never latch a collision
   a_front_no_risk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.risk_mask & FRONT_MASK) == '0))
      else $error("front sonar collision latch set");

   // a stop pulse always comes with a set latch
   a_stop_has_risk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.stop_command) |-> (rsp_payload.risk_mask != '0))
      else $error("stop without latched risk");

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

/* tb/sv/sonar_approach_collision_monitor_tb.sv */
// Self-checking testbench for the sonar approach and collision monitor.
`timescale 1ns / 100ps

module sonar_approach_collision_monitor_tb;
   import sacm_pkg::*;

   localparam int                DEPTH         = HISTORY_DEPTH_DEFAULT;
   localparam logic [DIST_W-1:0] RESET_READING = 16'd700;
   localparam int                CYCLE_LIMIT   = 200000;
   localparam int                IDLE_PCT      = 23;
   localparam int                HOLD_CYCLES   = 300;
   localparam int                PHASE_ITEMS   = 276;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_payload;
   logic              csr_valid;
   logic              csr_ready;
   logic [DIST_W-1:0] csr_wdata;

   // predictor state
   logic [DIST_W-1:0]       sonar_log [SENSOR_COUNT][DEPTH];
   int                      log_ptr [SENSOR_COUNT];
   int                      log_fill [SENSOR_COUNT];
   logic [SENSOR_COUNT-1:0] risk_latch;
   logic [DIST_W-1:0]       threshold;

   req_type pending_readings [$];
   rsp_type expected_results [$];

   bit steady;
   bit hold_req;
   bit hold_seen;
   bit req_took;
   int hold_left;
   int threshold_writes;
   int mismatch_count;
   int result_count;
   int cycle_count;

   sonar_approach_collision_monitor dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // k = 1 is the newest entry, k = DEPTH the oldest
   function automatic logic [DIST_W-1:0] past_reading(int s, int k);
      return sonar_log[s][(log_ptr[s] + DEPTH - k) % DEPTH];
   endfunction

   function automatic rsp_type predict_reading(req_type r);
      rsp_type res;
      int      s;
      int      k;
      logic    falling;
      res = '0;
      if (r.sensor_index < SENSOR_COUNT) begin
         s = r.sensor_index;
         sonar_log[s][log_ptr[s]] = r.distance;
         log_ptr[s] = (log_ptr[s] + 1) % DEPTH;
         if (log_fill[s] < DEPTH) log_fill[s]++;
      end
      for (s = 0; s < SENSOR_COUNT; s++) begin
         if (FRONT_MASK[s] && log_fill[s] == DEPTH) begin
            falling = 1'b1;
            for (k = DEPTH; k > 1; k--)
               if (!(past_reading(s, k) > past_reading(s, k - 1))) falling = 1'b0;
            if (falling) res.approaching = 1'b1;
         end
      end
      for (s = 0; s < SENSOR_COUNT; s++) begin
         if (SIDE_MASK[s] && log_fill[s] != 0) begin
            if (past_reading(s, 1) < threshold) begin
               if (!risk_latch[s]) begin
                  risk_latch[s] = 1'b1;
                  res.stop_command = 1'b1;
               end
            end else begin
               risk_latch[s] = 1'b0;
            end
         end
      end
      res.risk_mask = risk_latch;
      return res;
   endfunction

   // transfer monitor: prediction on req, checking on rsp, threshold on csr
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_took = 1'b0;
      end else begin
         req_took = req_valid && req_ready;
         if (req_took) expected_results.push_back(predict_reading(req_payload));
         if (csr_valid && csr_ready) begin
            threshold = csr_wdata;
            threshold_writes++;
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d: none expected, got %b/%b/%b", result_count,
                           rsp_payload.approaching, rsp_payload.stop_command,
                           rsp_payload.risk_mask);
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.approaching !== want.approaching ||
                   rsp_payload.stop_command !== want.stop_command ||
                   rsp_payload.risk_mask !== want.risk_mask) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result %0d: approaching %b/%b stop %b/%b mask %b/%b (exp/got)",
                              result_count, want.approaching, rsp_payload.approaching,
                              want.stop_command, rsp_payload.stop_command,
                              want.risk_mask, rsp_payload.risk_mask);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** sonar_approach_collision_monitor: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_readings.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_valid   <= 1'b1;
            req_payload <= pending_readings.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   task automatic queue_reading(int s, int d);
      req_type r;
      r.sensor_index = s[IDX_W-1:0];
      r.distance     = d[DIST_W-1:0];
      pending_readings.push_back(r);
   endtask

   function automatic int clamp_dist(int d);
      return (d < 0) ? 0 : (d > 65535) ? 65535 : d;
   endfunction

   task automatic queue_random_readings(int count);
      int n;
      int len;
      int s;
      int d;
      int i;
      n = 0;
      while (n < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               // falling run on one sonar, front sonars favoured
               s   = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(0, 6);
               len = $urandom_range(2, 6);
               d   = $urandom_range(0, 65535);
               for (i = 0; i < len; i++) begin
                  queue_reading(s, d);
                  n++;
                  d = clamp_dist(d - (($urandom_range(0, 7) == 0) ? 0
                                                                  : $urandom_range(1, 4000)));
               end
            end
            5, 6, 7: begin
               queue_reading($urandom_range(0, 7),
                             clamp_dist(int'(threshold) + $urandom_range(0, 4) - 2));
               n++;
            end
            default: begin
               queue_reading($urandom_range(0, 7), $urandom_range(0, 65535));
               n++;
            end
         endcase
      end
   endtask

   task automatic write_threshold(logic [DIST_W-1:0] value);
      int target;
      target = threshold_writes + 1;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      wait (threshold_writes == target);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_readings.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   initial begin
      logic [DIST_W-1:0] phase_threshold [5];
      int                p;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_wdata   = '0;
      threshold   = THRESHOLD_RESET;
      risk_latch  = '0;
      foreach (sonar_log[s, j]) sonar_log[s][j] = RESET_READING;
      foreach (log_ptr[s]) begin
         log_ptr[s]  = 0;
         log_fill[s] = 0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty histories, threshold edges, falling and flat front runs
      queue_reading(7, 123);
      queue_reading(0, 299);
      queue_reading(0, 100);
      queue_reading(0, 300);
      queue_reading(4, 0);
      queue_reading(5, 65535);
      queue_reading(6, 299);
      queue_reading(7, 0);
      queue_reading(2, 4000);
      queue_reading(2, 3000);
      queue_reading(2, 2000);
      queue_reading(2, 1000);
      queue_reading(2, 1000);
      queue_reading(1, 65535);
      queue_reading(1, 40000);
      queue_reading(1, 40000);
      queue_reading(1, 1);
      queue_reading(3, 65535);
      queue_reading(3, 20000);
      queue_reading(3, 10000);
      queue_reading(3, 0);
      queue_reading(6, 301);
      queue_reading(4, 65535);
      queue_reading(5, 0);
      wait_drained();

      phase_threshold = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(0, 65535)), 16'd300};
      for (p = 0; p < 5; p++) begin
         write_threshold(phase_threshold[p]);
         steady = (p == 2);
         if (p == 1) hold_req = ~hold_req;
         queue_random_readings(PHASE_ITEMS);
         wait_drained();
      end
      steady = 1'b0;

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("** sonar_approach_collision_monitor: PASSED **");
      else
         $display("** sonar_approach_collision_monitor: FAILED **");
      $finish;
   end

endmodule
